[hw/rtl/latd_pkg.sv]
// Package for the locality-aware task dispatcher: field widths, command codes,
// controller states, table entry layout and controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package latd_pkg;

    localparam int CMD_W      = 2;
    localparam int CHUNK_W    = 16;
    localparam int NODE_W     = 8;
    localparam int RANK_W     = 4;
    localparam int WCOUNT_W   = 4;
    localparam int COUNT_W    = 9;
    localparam int FOLD_CNT_W = $clog2(NODE_W + 1);

    localparam logic [COUNT_W-1:0]    COUNT_LIMIT      = 9'd511;
    localparam logic [WCOUNT_W-1:0]   WORKER_COUNT_RST = 4'd1;
    localparam logic [FOLD_CNT_W-1:0] FOLD_STEPS       = FOLD_CNT_W'(NODE_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_COMPLETE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FOLD,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [RANK_W-1:0]   node;
        logic [CHUNK_W-1:0]  chunk;
    } entry_t;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic fold_start;
        logic write_entry;
        logic scan_start;
        logic remove_entry;
        logic set_none;
        logic set_drop;
        logic count_update;
        logic rsp_load;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             req_valid;
        logic             table_full;
        logic             table_empty;
        logic             fold_done;
        logic             scan_done;
        logic             scan_found;
        logic             rsp_free;
    } status_t;

endpackage

`default_nettype wire

[hw/rtl/latd_if.sv]
// Request and response channel interfaces of the task dispatcher.
// Depends on latd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface latd_req_if;
    logic                          valid;
    logic                          ready;
    logic [latd_pkg::CMD_W-1:0]    command;
    logic [latd_pkg::CHUNK_W-1:0]  chunk_index;
    logic [latd_pkg::NODE_W-1:0]   preferred_node;
    logic [latd_pkg::RANK_W-1:0]   worker_rank;

    modport source (output valid, command, chunk_index, preferred_node, worker_rank,
                    input ready);
    modport sink   (input valid, command, chunk_index, preferred_node, worker_rank,
                    output ready);
endinterface

interface latd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [latd_pkg::CHUNK_W-1:0]  granted_chunk;
    logic                          is_local;
    logic                          none_left;
    logic                          all_done;
    logic                          load_dropped;

    modport source (output valid, granted_chunk, is_local, none_left, all_done,
                    load_dropped, input ready);
    modport sink   (input valid, granted_chunk, is_local, none_left, all_done,
                    load_dropped, output ready);
endinterface

`default_nettype wire

[hw/rtl/locality_aware_task_dispatcher_top.sv]
// Top level of the locality-aware task dispatcher: joins controller and datapath.
// Depends on latd_pkg, latd_if, latd_ctrl and latd_dpath.
//
// One request is in flight at a time; a finished response waits in an output
// register, so the next request is taken while it is unclaimed. A load passes
// through decode, the bit-serial modulo fold of the preferred node, the table
// write and the response. A load dropped on a full table, a completion report,
// an unused command and a dispatch on an empty table go from decode straight to
// the response. A dispatch reads the table memory one entry a cycle, up to and
// including the first entry preferring the requester; when no entry prefers the
// requester the scan reads every slot below the append position. A response that
// finds the previous one still unclaimed holds the controller until that transfer.
// The table needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module locality_aware_task_dispatcher_top #(
    parameter int MAX_ENTRIES = 256,
    parameter int MAX_WORKERS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [latd_pkg::WCOUNT_W-1:0]  cfg_wr_data,
    latd_req_if.sink                            req,
    latd_rsp_if.source                          rsp
);

    latd_pkg::ctrl_t   ctrl;
    latd_pkg::status_t st;

    latd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl)
    );

    latd_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_WORKERS (MAX_WORKERS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp),
        .ctrl        (ctrl),
        .st          (st)
    );

endmodule

`default_nettype wire

[hw/rtl/latd_ctrl.sv]
// Controller state machine of the task dispatcher: sequences decode, node folding,
// table scan, removal and response. Depends on latd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module latd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire latd_pkg::status_t st,
    output latd_pkg::ctrl_t        ctrl
);

    latd_pkg::state_t state_reg;
    latd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= latd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            latd_pkg::S_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (st.req_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = latd_pkg::S_DECODE;
                end
            end
            latd_pkg::S_DECODE:
            begin
                state_next = latd_pkg::S_RESP;
                case (st.cmd)
                    latd_pkg::CMD_LOAD:
                    begin
                        if (st.table_full)
                        begin
                            ctrl.set_drop = 1'b1;
                        end
                        else
                        begin
                            ctrl.fold_start = 1'b1;
                            state_next      = latd_pkg::S_FOLD;
                        end
                    end
                    latd_pkg::CMD_DISPATCH:
                    begin
                        if (st.table_empty)
                        begin
                            ctrl.set_none = 1'b1;
                        end
                        else
                        begin
                            ctrl.scan_start = 1'b1;
                            state_next      = latd_pkg::S_SCAN;
                        end
                    end
                    latd_pkg::CMD_COMPLETE:
                    begin
                        ctrl.count_update = 1'b1;
                    end
                    default:
                    begin
                        state_next = latd_pkg::S_RESP;
                    end
                endcase
            end
            latd_pkg::S_FOLD:
            begin
                if (st.fold_done)
                begin
                    ctrl.write_entry = 1'b1;
                    state_next       = latd_pkg::S_RESP;
                end
            end
            latd_pkg::S_SCAN:
            begin
                if (st.scan_done)
                begin
                    if (st.scan_found)
                    begin
                        ctrl.remove_entry = 1'b1;
                    end
                    else
                    begin
                        ctrl.set_none = 1'b1;
                    end
                    state_next = latd_pkg::S_RESP;
                end
            end
            latd_pkg::S_RESP:
            begin
                if (st.rsp_free)
                begin
                    ctrl.rsp_load = 1'b1;
                    state_next    = latd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = latd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/latd_dpath.sv]
// Datapath of the task dispatcher: request capture, task table memory, scan
// pipeline, modulo fold unit, per-worker counters and response register.
// Depends on latd_pkg and the channel interfaces in latd_if.
`timescale 1ns / 1ps
`default_nettype none

module latd_dpath #(
    parameter int MAX_ENTRIES = 256,
    parameter int MAX_WORKERS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [latd_pkg::WCOUNT_W-1:0]   cfg_wr_data,
    latd_req_if.sink                             req,
    latd_rsp_if.source                           rsp,
    input  wire latd_pkg::ctrl_t                 ctrl,
    output latd_pkg::status_t                    st
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int WK_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int RK_W  = (WK_W > latd_pkg::RANK_W) ? WK_W : latd_pkg::RANK_W;

    localparam logic [CNT_W-1:0] TABLE_SIZE = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    // captured request
    logic [latd_pkg::CMD_W-1:0]    cmd_reg;
    logic [latd_pkg::CHUNK_W-1:0]  chunk_reg;
    logic [latd_pkg::NODE_W-1:0]   node_reg;
    logic [latd_pkg::RANK_W-1:0]   rank_reg;

    logic [latd_pkg::WCOUNT_W-1:0] worker_count_reg;
    logic [CNT_W-1:0]              append_reg;
    logic [CNT_W-1:0]              pending_reg;

    // task table
    latd_pkg::entry_t              entry_mem [MAX_ENTRIES];
    latd_pkg::entry_t              rd_q_reg;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_wa;
    latd_pkg::entry_t              mem_wd;

    // scan pipeline
    logic                          scan_busy_reg;
    logic                          scan_done_reg;
    logic                          chk_vld_reg;
    logic [IDX_W-1:0]              chk_idx_reg;
    logic [CNT_W-1:0]              iss_idx_reg;
    logic                          first_found_reg;
    logic                          match_found_reg;
    logic [IDX_W-1:0]              sel_idx_reg;
    logic [latd_pkg::CHUNK_W-1:0]  sel_chunk_reg;
    logic                          issue_ok;
    logic                          hit_valid;
    logic                          hit_match;

    // fold unit
    logic [latd_pkg::NODE_W-1:0]     dvd_reg;
    logic [latd_pkg::RANK_W-1:0]     rem_reg;
    logic [latd_pkg::FOLD_CNT_W-1:0] fold_left_reg;
    logic [latd_pkg::RANK_W:0]       fold_trial;
    logic [latd_pkg::RANK_W:0]       fold_diff;
    logic [latd_pkg::RANK_W-1:0]     rem_next;
    logic [latd_pkg::RANK_W-1:0]     fold_node;

    // worker counters
    logic [latd_pkg::COUNT_W-1:0]  cnt_reg [MAX_WORKERS];
    logic [RK_W-1:0]               rank_wide;
    logic [WK_W-1:0]               cnt_idx;
    logic                          has_counter;
    logic [latd_pkg::COUNT_W-1:0]  cnt_cur;

    // result flags and response register
    logic                          grant_reg;
    logic                          none_reg;
    logic                          drop_reg;
    logic                          done_val;
    logic                          out_valid_reg;
    logic [latd_pkg::CHUNK_W-1:0]  out_chunk_reg;
    logic                          out_local_reg;
    logic                          out_none_reg;
    logic                          out_done_reg;
    logic                          out_drop_reg;

    assign req.ready = ctrl.in_ready;

    assign st.cmd         = cmd_reg;
    assign st.req_valid   = req.valid;
    assign st.table_full  = (append_reg == TABLE_SIZE);
    assign st.table_empty = (pending_reg == '0);
    assign st.fold_done   = (fold_left_reg == '0);
    assign st.scan_done   = scan_done_reg;
    assign st.scan_found  = first_found_reg;
    assign st.rsp_free    = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= req.command;
            chunk_reg <= req.chunk_index;
            node_reg  <= req.preferred_node;
            rank_reg  <= req.worker_rank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worker_count_reg <= latd_pkg::WORKER_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            worker_count_reg <= cfg_wr_data;
        end
    end

    // fold: restoring remainder, one dividend bit per cycle
    assign fold_trial = {rem_reg, dvd_reg[latd_pkg::NODE_W-1]};
    assign fold_diff  = fold_trial - {1'b0, worker_count_reg};
    assign rem_next   = (fold_trial >= {1'b0, worker_count_reg}) ?
                        fold_diff[latd_pkg::RANK_W-1:0] : fold_trial[latd_pkg::RANK_W-1:0];

    always_comb
    begin
        if (node_reg > latd_pkg::NODE_W'(worker_count_reg))
        begin
            fold_node = (worker_count_reg == '0) ? '0 : rem_reg;
        end
        else
        begin
            fold_node = node_reg[latd_pkg::RANK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_left_reg <= '0;
        end
        else if (ctrl.fold_start)
        begin
            fold_left_reg <= latd_pkg::FOLD_STEPS;
        end
        else if (fold_left_reg != '0)
        begin
            fold_left_reg <= fold_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fold_start)
        begin
            dvd_reg <= node_reg;
            rem_reg <= '0;
        end
        else if (fold_left_reg != '0)
        begin
            dvd_reg <= {dvd_reg[latd_pkg::NODE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // table memory
    assign mem_we = ctrl.write_entry || ctrl.remove_entry;
    assign mem_wa = ctrl.write_entry ? append_reg[IDX_W-1:0] : sel_idx_reg;

    always_comb
    begin
        mem_wd = '0;
        if (ctrl.write_entry)
        begin
            mem_wd.valid = 1'b1;
            mem_wd.node  = fold_node;
            mem_wd.chunk = chunk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_q_reg <= entry_mem[iss_idx_reg[IDX_W-1:0]];
    end

    // scan: issue one read a cycle, check the returned entry in the following cycle
    assign issue_ok  = scan_busy_reg && !match_found_reg && (iss_idx_reg < append_reg);
    assign hit_valid = chk_vld_reg && rd_q_reg.valid;
    assign hit_match = hit_valid && (rd_q_reg.node == rank_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_busy_reg   <= 1'b0;
            scan_done_reg   <= 1'b0;
            chk_vld_reg     <= 1'b0;
            first_found_reg <= 1'b0;
            match_found_reg <= 1'b0;
            iss_idx_reg     <= '0;
        end
        else if (ctrl.scan_start)
        begin
            scan_busy_reg   <= 1'b1;
            scan_done_reg   <= 1'b0;
            chk_vld_reg     <= 1'b0;
            first_found_reg <= 1'b0;
            match_found_reg <= 1'b0;
            iss_idx_reg     <= '0;
        end
        else if (scan_busy_reg)
        begin
            chk_vld_reg <= issue_ok;
            if (issue_ok)
            begin
                iss_idx_reg <= iss_idx_reg + CNT_ONE;
            end
            if (hit_valid)
            begin
                first_found_reg <= 1'b1;
            end
            if (hit_match)
            begin
                match_found_reg <= 1'b1;
                scan_busy_reg   <= 1'b0;
                scan_done_reg   <= 1'b1;
            end
            else if (!chk_vld_reg && !issue_ok)
            begin
                scan_busy_reg <= 1'b0;
                scan_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_busy_reg)
        begin
            chk_idx_reg <= iss_idx_reg[IDX_W-1:0];
            if (hit_match || (hit_valid && !first_found_reg))
            begin
                sel_idx_reg   <= chk_idx_reg;
                sel_chunk_reg <= rd_q_reg.chunk;
            end
        end
    end

    // table occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            append_reg  <= '0;
            pending_reg <= '0;
        end
        else if (ctrl.write_entry)
        begin
            append_reg  <= append_reg + CNT_ONE;
            pending_reg <= pending_reg + CNT_ONE;
        end
        else if (ctrl.remove_entry)
        begin
            pending_reg <= pending_reg - CNT_ONE;
            if (pending_reg == CNT_ONE)
            begin
                append_reg <= '0;
            end
        end
    end

    // worker counters
    assign rank_wide   = RK_W'(rank_reg);
    assign cnt_idx     = rank_wide[WK_W-1:0];
    assign has_counter = (int'(rank_reg) < MAX_WORKERS);
    assign cnt_cur     = has_counter ? cnt_reg[cnt_idx] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WORKERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (ctrl.remove_entry && has_counter && (cnt_cur < latd_pkg::COUNT_LIMIT))
        begin
            cnt_reg[cnt_idx] <= cnt_cur + 1'b1;
        end
        else if (ctrl.count_update && has_counter && (chunk_reg != '0) && (cnt_cur != '0))
        begin
            cnt_reg[cnt_idx] <= cnt_cur - 1'b1;
        end
    end

    // result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_reg <= 1'b0;
            none_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            grant_reg <= 1'b0;
            none_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.remove_entry)
            begin
                grant_reg <= 1'b1;
            end
            if (ctrl.set_none)
            begin
                none_reg <= 1'b1;
            end
            if (ctrl.set_drop)
            begin
                drop_reg <= 1'b1;
            end
        end
    end

    assign done_val = (cmd_reg == latd_pkg::CMD_COMPLETE) && (cnt_cur == '0) &&
                      (pending_reg == '0);

    // response register: hold until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.rsp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rsp_load)
        begin
            out_chunk_reg <= grant_reg ? sel_chunk_reg : '0;
            out_local_reg <= grant_reg && match_found_reg;
            out_none_reg  <= none_reg;
            out_done_reg  <= done_val;
            out_drop_reg  <= drop_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_chunk = out_chunk_reg;
    assign rsp.is_local      = out_local_reg;
    assign rsp.none_left     = out_none_reg;
    assign rsp.all_done      = out_done_reg;
    assign rsp.load_dropped  = out_drop_reg;

endmodule

`default_nettype wire

[tb/locality_aware_task_dispatcher_top_tb.sv]
// Testbench for the locality-aware task dispatcher: queued stimulus, a bursty
// request driver, a stalling response monitor and a scoreboard against a local model.
// Depends on latd_pkg, latd_if and locality_aware_task_dispatcher_top.
`timescale 1ns / 1ps

module locality_aware_task_dispatcher_top_tb;

    localparam int MAX_ENTRIES  = 256;
    localparam int MAX_WORKERS  = 16;
    localparam int LIMIT_CYCLES = 4000000;
    localparam logic [latd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                         drain;
        logic [latd_pkg::CMD_W-1:0]   command;
        logic [latd_pkg::CHUNK_W-1:0] chunk_index;
        logic [latd_pkg::NODE_W-1:0]  preferred_node;
        logic [latd_pkg::RANK_W-1:0]  worker_rank;
    } task_req_t;

    typedef struct packed {
        logic [latd_pkg::CHUNK_W-1:0] granted_chunk;
        logic                         is_local;
        logic                         none_left;
        logic                         all_done;
        logic                         load_dropped;
    } reply_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [latd_pkg::WCOUNT_W-1:0] cfg_wr_data;

    latd_req_if req_ch ();
    latd_rsp_if rsp_ch ();

    locality_aware_task_dispatcher_top #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_WORKERS (MAX_WORKERS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Dispatcher model state
    logic [latd_pkg::CHUNK_W-1:0]  slot_chunk [MAX_ENTRIES];
    logic [latd_pkg::RANK_W-1:0]   slot_node  [MAX_ENTRIES];
    logic                          slot_live  [MAX_ENTRIES];
    int                            fill_pos;
    int                            live_count;
    int                            busy_count [MAX_WORKERS];
    logic [latd_pkg::WCOUNT_W-1:0] fold_base;

    task_req_t task_q [$];
    reply_t    reply_q [$];
    task_req_t cur_task;
    logic      offer;
    logic      in_flight;
    int        gap_left;
    int        burst_left;
    int        stall_mode;
    int        mode_left;
    int        rsp_tick;
    int        fail_count = 0;
    int        cycle_count = 0;

    function automatic reply_t predict_reply(task_req_t t);
        reply_t                      r;
        int                          pick;
        int                          hit;
        int                          busy;
        int                          i;
        logic [latd_pkg::NODE_W-1:0] n;
        logic                        counted;
        r = '0;
        counted = int'(t.worker_rank) < MAX_WORKERS;
        case (t.command)
            latd_pkg::CMD_LOAD:
            begin
                if (fill_pos >= MAX_ENTRIES)
                begin
                    r.load_dropped = 1'b1;
                end
                else
                begin
                    n = t.preferred_node;
                    if (n > latd_pkg::NODE_W'(fold_base))
                    begin
                        n = (fold_base == '0) ? '0 : n % latd_pkg::NODE_W'(fold_base);
                    end
                    slot_chunk[fill_pos] = t.chunk_index;
                    slot_node[fill_pos]  = n[latd_pkg::RANK_W-1:0];
                    slot_live[fill_pos]  = 1'b1;
                    fill_pos++;
                    live_count++;
                end
            end
            latd_pkg::CMD_DISPATCH:
            begin
                if (live_count == 0)
                begin
                    r.none_left = 1'b1;
                end
                else
                begin
                    pick = -1;
                    hit  = -1;
                    for (i = 0; i < fill_pos && hit < 0; i++)
                    begin
                        if (slot_live[i])
                        begin
                            if (pick < 0)
                                pick = i;
                            if (slot_node[i] == t.worker_rank)
                                hit = i;
                        end
                    end
                    if (hit >= 0)
                    begin
                        r.is_local = 1'b1;
                        pick = hit;
                    end
                    if (pick < 0)
                    begin
                        r.none_left = 1'b1;
                    end
                    else
                    begin
                        r.granted_chunk = slot_chunk[pick];
                        slot_live[pick] = 1'b0;
                        live_count--;
                        if (live_count == 0)
                            fill_pos = 0;
                        if (counted && busy_count[t.worker_rank] < int'(latd_pkg::COUNT_LIMIT))
                            busy_count[t.worker_rank]++;
                    end
                end
            end
            latd_pkg::CMD_COMPLETE:
            begin
                busy = 0;
                if (counted)
                begin
                    if (t.chunk_index != '0 && busy_count[t.worker_rank] > 0)
                        busy_count[t.worker_rank]--;
                    busy = busy_count[t.worker_rank];
                end
                r.all_done = (busy == 0 && live_count == 0);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic queue_task(logic [latd_pkg::CMD_W-1:0] cmd, int chunk, int node, int rank,
                              logic drain = 1'b0);
        task_req_t t;
        t.drain          = drain;
        t.command        = cmd;
        t.chunk_index    = latd_pkg::CHUNK_W'(chunk);
        t.preferred_node = latd_pkg::NODE_W'(node);
        t.worker_rank    = latd_pkg::RANK_W'(rank);
        task_q.insert(task_q.size(), t);
    endtask

    task automatic queue_random(logic drain);
        int pick;
        int node;
        int chunk;
        pick  = $urandom_range(0, 99);
        node  = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
        chunk = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535);
        if (pick < 40)
            queue_task(latd_pkg::CMD_LOAD, chunk, node, $urandom_range(0, 15), drain);
        else if (pick < 75)
            queue_task(latd_pkg::CMD_DISPATCH, chunk, node, $urandom_range(0, 15), drain);
        else if (pick < 95)
            queue_task(latd_pkg::CMD_COMPLETE, chunk, node, $urandom_range(0, 15), drain);
        else
            queue_task(CMD_UNUSED, chunk, node, $urandom_range(0, 15), drain);
    endtask

    task automatic wait_drained();
        while (task_q.size() != 0 || in_flight || reply_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_worker_count(int value);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= latd_pkg::WCOUNT_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        fold_base = latd_pkg::WCOUNT_W'(value);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: bursts with random gaps, optional hold until drained
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid          <= 1'b0;
            req_ch.command        <= '0;
            req_ch.chunk_index    <= '0;
            req_ch.preferred_node <= '0;
            req_ch.worker_rank    <= '0;
            in_flight  = 1'b0;
            gap_left   = 0;
            burst_left = 1;
            fill_pos   = 0;
            live_count = 0;
            for (int k = 0; k < MAX_ENTRIES; k++)
            begin
                slot_chunk[k] = '0;
                slot_node[k]  = '0;
                slot_live[k]  = 1'b0;
            end
            for (int k = 0; k < MAX_WORKERS; k++)
                busy_count[k] = 0;
        end
        else
        begin
            offer = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                reply_q.insert(reply_q.size(), predict_reply(cur_task));
                offer     = 1'b0;
                in_flight = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (task_q.size() != 0 && !(task_q[0].drain && reply_q.size() != 0))
                begin
                    cur_task = task_q.pop_front();
                    req_ch.command        <= cur_task.command;
                    req_ch.chunk_index    <= cur_task.chunk_index;
                    req_ch.preferred_node <= cur_task.preferred_node;
                    req_ch.worker_rank    <= cur_task.worker_rank;
                    offer     = 1'b1;
                    in_flight = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            req_ch.valid <= offer;
        end
    end

    // Response monitor and scoreboard
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
            rsp_tick   = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("reply with no pending expectation");
                    fail_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    check_field("granted_chunk", want.granted_chunk, rsp_ch.granted_chunk);
                    check_field("is_local", want.is_local, rsp_ch.is_local);
                    check_field("none_left", want.none_left, rsp_ch.none_left);
                    check_field("all_done", want.all_done, rsp_ch.all_done);
                    check_field("load_dropped", want.load_dropped, rsp_ch.load_dropped);
                end
            end
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            rsp_tick++;
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= (rsp_tick % 4 == 0);
                default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int sat_rank;
        int i;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        fold_base   = latd_pkg::WORKER_COUNT_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, counter floor, unused command, folding, locality
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 0);
        queue_task(latd_pkg::CMD_COMPLETE, 0, 0, 0);
        queue_task(latd_pkg::CMD_COMPLETE, 16'hFFFF, 8'hFF, 15);
        queue_task(CMD_UNUSED, 16'hFFFF, 8'hFF, 15);
        queue_task(latd_pkg::CMD_LOAD, 16'hFFFF, 0, 0);
        queue_task(latd_pkg::CMD_LOAD, 0, 255, 15);
        queue_task(latd_pkg::CMD_LOAD, 1, 1, 0);
        queue_task(latd_pkg::CMD_LOAD, 16'hAAAA, 2, 0);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 1);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 15);
        queue_task(latd_pkg::CMD_COMPLETE, 1, 0, 1);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 0);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 0);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 7);
        queue_task(latd_pkg::CMD_COMPLETE, 0, 0, 15);
        queue_task(latd_pkg::CMD_COMPLETE, 16'h5555, 0, 15);
        queue_task(latd_pkg::CMD_COMPLETE, 1, 0, 0);
        set_worker_count(0);
        queue_task(latd_pkg::CMD_LOAD, 16'h1234, 0, 0);
        queue_task(latd_pkg::CMD_LOAD, 16'h4321, 255, 0);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 0);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 3);
        set_worker_count(15);
        queue_task(latd_pkg::CMD_LOAD, 16'h0F0F, 15, 0);
        queue_task(latd_pkg::CMD_LOAD, 16'h1010, 16, 0);
        queue_task(latd_pkg::CMD_LOAD, 16'hFF00, 255, 0);
        queue_task(latd_pkg::CMD_LOAD, 16'h00C8, 200, 0);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 5);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 15);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 1);
        queue_task(latd_pkg::CMD_DISPATCH, 0, 0, 0);

        // Drive one worker's counter into saturation, then back down
        set_worker_count(4);
        sat_rank = $urandom_range(0, 15);
        for (i = 0; i < 515; i++)
        begin
            queue_task(latd_pkg::CMD_LOAD, $urandom_range(1, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 15), (i == 200));
            queue_task(latd_pkg::CMD_DISPATCH, $urandom_range(0, 65535),
                       $urandom_range(0, 255), sat_rank);
            if ($urandom_range(0, 15) == 0)
                queue_task(latd_pkg::CMD_COMPLETE, $urandom_range(0, 65535),
                           $urandom_range(0, 255), (sat_rank + 1 + $urandom_range(0, 14)) % 16);
            else if ($urandom_range(0, 31) == 0)
                queue_task(CMD_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 255),
                           $urandom_range(0, 15));
        end
        for (i = 0; i < 20; i++)
            queue_task(latd_pkg::CMD_COMPLETE,
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 65535),
                       $urandom_range(0, 255), sat_rank);

        // Fill the table past capacity, then empty it
        set_worker_count($urandom_range(2, 14));
        for (i = 0; i < 258; i++)
            queue_task(latd_pkg::CMD_LOAD, $urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 15));
        for (i = 0; i < 40; i++)
            queue_random(1'b0);
        for (i = 0; i < 300; i++)
        begin
            queue_task(latd_pkg::CMD_DISPATCH, $urandom_range(0, 65535),
                       $urandom_range(0, 255), $urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0)
                queue_task(latd_pkg::CMD_COMPLETE, $urandom_range(0, 65535),
                           $urandom_range(0, 255), $urandom_range(0, 15));
        end

        // Random mix across several worker counts
        set_worker_count(15);
        for (i = 0; i < 80; i++)
            queue_random($urandom_range(0, 29) == 0);
        set_worker_count(0);
        for (i = 0; i < 80; i++)
            queue_random($urandom_range(0, 29) == 0);
        set_worker_count(1);
        for (i = 0; i < 80; i++)
            queue_random($urandom_range(0, 29) == 0);
        set_worker_count($urandom_range(2, 14));
        for (i = 0; i < 80; i++)
            queue_random($urandom_range(0, 29) == 0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && reply_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
